### sv/assert_macros.svh
// Assertion macros used by the integer matrix multiply RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising i_clk outside reset.
`define IMM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising i_clk outside reset.
`define IMM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### sv/imm_pkg.sv
// Shared constants, types and helpers for the integer matrix multiply block.
package imm_pkg;

    localparam int MAX_DIM     = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int DIM_W       = $clog2(MAX_DIM) + 1;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // op codes
    localparam logic [1:0] OP_WRITE_A = 2'd0;
    localparam logic [1:0] OP_WRITE_B = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    // register indexes (word address bits)
    localparam logic [1:0] REG_ROWS_M  = 2'd0;
    localparam logic [1:0] REG_COLS_N  = 2'd1;
    localparam logic [1:0] REG_INNER_K = 2'd2;
    localparam logic [1:0] REG_ACC     = 2'd3;

    // status codes
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    // control from the sequencer to the MAC unit
    typedef struct packed {
        logic clr;   // zero the sum, drop pending product
        logic vld;   // operand words on the RAM outputs are valid
    } t_mac_ctl;

    // status from the MAC unit back to the sequencer
    typedef struct packed {
        logic pending;  // a product is still waiting to be summed
    } t_mac_sts;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(MAX_DIM);
        return (d > lim) ? lim : d;
    endfunction

endpackage

### sv/imm_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/imm_mac.sv
// Shared multiply-accumulate unit: registered product, then wrapping sum.
module imm_mac import imm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mac_ctl              i_ctl,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output t_mac_sts              o_sts,
    output logic [DATA_WIDTH-1:0] o_sum
);

    logic [2*DATA_WIDTH-1:0] w_full;
    logic [DATA_WIDTH-1:0]   r_prod;
    logic                    r_prod_vld;
    logic [DATA_WIDTH-1:0]   r_sum;

    // low word of the product is the same for signed and unsigned
    assign w_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else if (i_ctl.clr) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_prod <= w_full[DATA_WIDTH-1:0];
        end
        if (i_ctl.clr) begin
            r_sum <= '0;
        end else if (r_prod_vld) begin
            r_sum <= r_sum + r_prod;
        end
    end

    assign o_sts.pending = r_prod_vld;
    assign o_sum         = r_sum;

endmodule

### sv/integer_matrix_multiply.sv
// Integer matrix multiply: A/B element stores, one shared MAC, C store with accumulate.
// Writes of A or B give no word back; the next word may follow at once.
// Compute: busy is high while one A/B read per term is issued (RUN) and the MAC drains
//   (DRAIN), RUN skipped when inner_k is zero; the result strobe is in the first cycle busy is low again.
// Out-of-range compute: busy stays low, strobe the next cycle; results cannot be held off.
// Sync active-low reset: config 16/16/16/overwrite, C valid bits cleared so C reads zero.
module integer_matrix_multiply import imm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_op,
    input  logic [IDX_W-1:0]      i_row_index,
    input  logic [IDX_W-1:0]      i_col_index,
    input  logic signed [31:0]    i_element_value,
    // result channel
    output logic                  o_result_valid,
    output logic signed [31:0]    o_product_value,
    output logic                  o_status,
    // APB-style config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [DIM_W-1:0] r_rows_m;
    logic [DIM_W-1:0] r_cols_n;
    logic [DIM_W-1:0] r_inner_k;
    logic             r_acc_mode;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_m   <= DIM_W'(MAX_DIM);
            r_cols_n   <= DIM_W'(MAX_DIM);
            r_inner_k  <= DIM_W'(MAX_DIM);
            r_acc_mode <= 1'b0;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_ROWS_M:  r_rows_m   <= pwdata[DIM_W-1:0];
                REG_COLS_N:  r_cols_n   <= pwdata[DIM_W-1:0];
                REG_INNER_K: r_inner_k  <= pwdata[DIM_W-1:0];
                REG_ACC:     r_acc_mode <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ROWS_M:  prdata = {{(32-DIM_W){1'b0}}, r_rows_m};
            REG_COLS_N:  prdata = {{(32-DIM_W){1'b0}}, r_cols_n};
            REG_INNER_K: prdata = {{(32-DIM_W){1'b0}}, r_inner_k};
            REG_ACC:     prdata = {31'b0, r_acc_mode};
            default:     prdata = '0;
        endcase
    end

    // sizes above MAX_DIM behave as MAX_DIM
    logic [DIM_W-1:0] w_m, w_n, w_k;
    assign w_m = clamp_dim(r_rows_m);
    assign w_n = clamp_dim(r_cols_n);
    assign w_k = clamp_dim(r_inner_k);

    // ---------------------------------------------------------------
    // Command decode
    // ---------------------------------------------------------------
    logic              w_accept;
    logic [DIM_W-1:0]  w_row_x, w_col_x;
    logic              w_row_lt_m, w_col_lt_n, w_row_lt_k, w_col_lt_k;
    logic              w_in_range;
    logic [ADDR_W-1:0] w_addr_in;

    assign w_accept   = start && !busy;
    assign w_row_x    = {1'b0, i_row_index};
    assign w_col_x    = {1'b0, i_col_index};
    assign w_row_lt_m = w_row_x < w_m;
    assign w_col_lt_n = w_col_x < w_n;
    assign w_row_lt_k = w_row_x < w_k;
    assign w_col_lt_k = w_col_x < w_k;
    assign w_in_range = w_row_lt_m && w_col_lt_n;
    assign w_addr_in  = {i_row_index, i_col_index};

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    t_state            r_state, n_state;
    logic [DIM_W-1:0]  r_t, n_t;          // term being issued
    logic [IDX_W-1:0]  r_row, r_col;      // latched C coordinates
    logic              r_rd_vld;          // A/B read issued last cycle
    logic              r_old_vld;         // stored C entry was ever written
    logic [STORE_DEPTH-1:0] r_c_valid;

    logic [DATA_WIDTH-1:0] w_a_rdata, w_b_rdata, w_c_rdata, w_sum;
    t_mac_ctl              w_mac_ctl;
    t_mac_sts              w_mac_sts;

    // next state
    always_comb begin
        n_state = r_state;
        n_t     = r_t;
        case (r_state)
            S_IDLE: begin
                n_t = '0;
                if (w_accept && i_op == OP_COMPUTE && w_in_range) begin
                    n_state = (w_k == '0) ? S_DRAIN : S_RUN;
                end
            end
            S_RUN: begin
                n_t = r_t + 1'b1;
                if (n_t >= w_k) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld && !w_mac_sts.pending) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // RAM, MAC and result controls
    logic                  w_a_we, w_b_we, w_ab_re, w_c_re, w_c_we;
    logic [ADDR_W-1:0]     w_a_raddr, w_b_raddr, w_c_addr;
    logic [DATA_WIDTH-1:0] w_old_c, w_result;
    logic                  n_out_vld, n_out_status;
    logic [DATA_WIDTH-1:0] n_out_val;

    assign w_old_c  = r_old_vld ? w_c_rdata : '0;
    assign w_result = r_acc_mode ? (w_old_c + w_sum) : w_sum;

    always_comb begin
        w_a_we        = 1'b0;
        w_b_we        = 1'b0;
        w_ab_re       = 1'b0;
        w_c_re        = 1'b0;
        w_c_we        = 1'b0;
        w_a_raddr     = {r_row, r_t[IDX_W-1:0]};
        w_b_raddr     = {r_t[IDX_W-1:0], r_col};
        w_c_addr      = {r_row, r_col};
        w_mac_ctl.clr = 1'b0;
        w_mac_ctl.vld = r_rd_vld;
        n_out_vld     = 1'b0;
        n_out_status  = ST_OK;
        n_out_val     = '0;
        case (r_state)
            S_IDLE: begin
                w_c_addr = w_addr_in;
                if (w_accept) begin
                    case (i_op)
                        OP_WRITE_A: w_a_we = w_row_lt_m && w_col_lt_k;
                        OP_WRITE_B: w_b_we = w_row_lt_k && w_col_lt_n;
                        OP_COMPUTE: begin
                            if (w_in_range) begin
                                w_c_re        = 1'b1;
                                w_mac_ctl.clr = 1'b1;
                            end else begin
                                n_out_vld    = 1'b1;
                                n_out_status = ST_RANGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RUN: begin
                w_ab_re = 1'b1;
            end
            S_DRAIN: begin
                if (!r_rd_vld && !w_mac_sts.pending) begin
                    w_c_we    = 1'b1;
                    n_out_vld = 1'b1;
                    n_out_val = w_result;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_t       <= '0;
            r_rd_vld  <= 1'b0;
            r_c_valid <= '0;
        end else begin
            r_state  <= n_state;
            r_t      <= n_t;
            r_rd_vld <= w_ab_re;
            if (w_c_we) begin
                r_c_valid[w_c_addr] <= 1'b1;
            end
        end
    end

    // latched coordinates and C-entry history
    always_ff @(posedge i_clk) begin
        if (w_c_re) begin
            r_row     <= i_row_index;
            r_col     <= i_col_index;
            r_old_vld <= r_c_valid[w_addr_in];
        end
    end

    // result word: one-cycle strobe, payload held in registers
    logic                  r_out_vld, r_out_status;
    logic [DATA_WIDTH-1:0] r_out_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_vld) begin
            r_out_val    <= n_out_val;
            r_out_status <= n_out_status;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_valid  = r_out_vld;
    assign o_product_value = r_out_val;
    assign o_status        = r_out_status;

    // ---------------------------------------------------------------
    // Stores and the shared MAC
    // ---------------------------------------------------------------
    imm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STORE_DEPTH)) u_a_store (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_addr_in),
        .i_wdata (i_element_value),
        .i_re    (w_ab_re),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    imm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STORE_DEPTH)) u_b_store (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_addr_in),
        .i_wdata (i_element_value),
        .i_re    (w_ab_re),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    // C read at accept, written back at finish; read data holds in between
    imm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STORE_DEPTH)) u_c_store (
        .i_clk   (i_clk),
        .i_we    (w_c_we),
        .i_waddr (w_c_addr),
        .i_wdata (w_result),
        .i_re    (w_c_re),
        .i_raddr (w_c_addr),
        .o_rdata (w_c_rdata)
    );

    imm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     (w_a_rdata),
        .i_b     (w_b_rdata),
        .o_sts   (w_mac_sts),
        .o_sum   (w_sum)
    );

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
`include "assert_macros.svh"

    `IMM_ASSERT_IMPL(a_err_zero, r_out_vld && r_out_status == ST_RANGE, r_out_val == '0)
    `IMM_ASSERT_IMPL(a_strobe_idle, r_out_vld, r_state == S_IDLE)
    `IMM_ASSERT_IMPL(a_run_term, r_state == S_RUN, r_t < w_k)
    `IMM_ASSERT_NEXT(a_compute_busy, w_accept && i_op == OP_COMPUTE && w_in_range, busy)

endmodule
